// ===== sv/mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mpt_pkg: shared definitions for the metadata page table
// widths, table geometry, mode and status codes, the queued command word
// ----------------------------------------------------------------------------
package mpt_pkg;

	// table geometry
	localparam int PAGE_SHIFT      = 12;
	localparam int META_UNIT_BYTES = 8;
	localparam int TABLE_ENTRIES   = 4096;
	localparam int IDX_W           = $clog2(TABLE_ENTRIES);
	localparam int CNT_W           = IDX_W + 1;

	// field widths
	localparam int MODE_W      = 2;
	localparam int ADDR_W      = 48;
	localparam int SIZE_W      = 49;
	localparam int BASE_W      = 56;
	localparam int ALIGN_W     = 6;
	localparam int ENTRY_W     = 64;
	localparam int STATUS_W    = 2;
	localparam int ALIGN_BYTE_W = ENTRY_W - BASE_W;
	localparam int PG_W        = ADDR_W - PAGE_SHIFT;
	localparam int PCNT_W      = SIZE_W - PAGE_SHIFT;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// mode codes
	localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RAW    = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SIZE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef enum logic [1:0] {
		KIND_REPORT,
		KIND_FILL,
		KIND_LOOKUP,
		KIND_RAW
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [STATUS_W-1:0]   status;
		logic [IDX_W-1:0]      page;
		logic [CNT_W-1:0]      count;
		logic [BASE_W-1:0]     base;
		logic [ALIGN_W-1:0]    align;
		logic [PAGE_SHIFT-1:0] offset;
	} cmd_t;

	// scale a unit count to bytes, kept to the base width
	function automatic logic [BASE_W-1:0] scale_unit(input logic [BASE_W-1:0] v);
		return BASE_W'(v * BASE_W'(META_UNIT_BYTES));
	endfunction

endpackage

// ===== sv/mpt_if.sv =====
// ----------------------------------------------------------------------------
// mpt_if: request and response channels of the metadata page table
// valid/ready handshake, a word moves when both are high at a clock edge
// ----------------------------------------------------------------------------
interface mpt_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [mpt_pkg::MODE_W-1:0]     mode;
	logic [mpt_pkg::ADDR_W-1:0]     address;
	logic [mpt_pkg::SIZE_W-1:0]     size_bytes;
	logic [mpt_pkg::BASE_W-1:0]     metadata_base;
	logic [mpt_pkg::ALIGN_W-1:0]    align_shift;

	modport source(output valid, mode, address, size_bytes, metadata_base, align_shift,
		input ready);
	modport sink(input valid, mode, address, size_bytes, metadata_base, align_shift,
		output ready);
endinterface

interface mpt_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [mpt_pkg::BASE_W-1:0]     meta_address;
	logic [mpt_pkg::ENTRY_W-1:0]    entry_word;
	logic [mpt_pkg::STATUS_W-1:0]   status;

	modport source(output valid, meta_address, entry_word, status, input ready);
	modport sink(input valid, meta_address, entry_word, status, output ready);
endinterface

// ===== sv/mpt_front.sv =====
// ----------------------------------------------------------------------------
// mpt_front: request intake and classification
// checks range and window, turns each request word into a queued command
// ----------------------------------------------------------------------------
module mpt_front (
	mpt_cmd_if.sink             cmd,
	input  logic                q_full,
	input  logic                clearing,
	output logic                push,
	output mpt_pkg::cmd_t       push_cmd
);

	logic [mpt_pkg::PG_W-1:0]   page_full;
	logic [mpt_pkg::PCNT_W-1:0] count_full;
	logic                       size_rem;
	logic                       page_out;
	logic [mpt_pkg::CNT_W-1:0]  room;

	assign cmd.ready = !q_full && !clearing;
	assign push      = cmd.valid && cmd.ready;

	assign page_full  = cmd.address[mpt_pkg::ADDR_W-1:mpt_pkg::PAGE_SHIFT];
	assign count_full = cmd.size_bytes[mpt_pkg::SIZE_W-1:mpt_pkg::PAGE_SHIFT];
	assign size_rem   = |cmd.size_bytes[mpt_pkg::PAGE_SHIFT-1:0];
	assign page_out   = page_full >= mpt_pkg::PG_W'(mpt_pkg::TABLE_ENTRIES);
	// pages left from the first page to the end of the table
	assign room = mpt_pkg::CNT_W'(mpt_pkg::TABLE_ENTRIES)
		- mpt_pkg::CNT_W'(page_full[mpt_pkg::IDX_W-1:0]);

	always_comb begin
		push_cmd        = '0;
		push_cmd.kind   = mpt_pkg::KIND_REPORT;
		push_cmd.status = mpt_pkg::STATUS_OK;
		push_cmd.page   = page_full[mpt_pkg::IDX_W-1:0];
		push_cmd.count  = mpt_pkg::CNT_W'(count_full);
		push_cmd.base   = cmd.metadata_base;
		push_cmd.align  = cmd.align_shift;
		push_cmd.offset = cmd.address[mpt_pkg::PAGE_SHIFT-1:0];
		case (cmd.mode)
			mpt_pkg::MODE_SET: begin
				if (size_rem) begin
					push_cmd.status = mpt_pkg::STATUS_SIZE;
				end else if (count_full == '0) begin
					push_cmd.status = mpt_pkg::STATUS_OK;
				end else if (page_out || count_full > mpt_pkg::PCNT_W'(room)) begin
					push_cmd.status = mpt_pkg::STATUS_RANGE;
				end else begin
					push_cmd.kind = mpt_pkg::KIND_FILL;
				end
			end
			mpt_pkg::MODE_LOOKUP: begin
				if (page_out) push_cmd.status = mpt_pkg::STATUS_RANGE;
				else push_cmd.kind = mpt_pkg::KIND_LOOKUP;
			end
			mpt_pkg::MODE_RAW: begin
				if (page_out) push_cmd.status = mpt_pkg::STATUS_RANGE;
				else push_cmd.kind = mpt_pkg::KIND_RAW;
			end
			default: begin
				push_cmd.kind = mpt_pkg::KIND_REPORT;
			end
		endcase
	end

endmodule

// ===== sv/mpt_queue.sv =====
// ----------------------------------------------------------------------------
// mpt_queue: short command queue between front and back
// lets intake go on while the back is busy filling a range
// ----------------------------------------------------------------------------
module mpt_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mpt_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output logic                full,
	output logic                head_valid,
	output mpt_pkg::cmd_t       head
);

	mpt_pkg::cmd_t                slots_q [mpt_pkg::QUEUE_DEPTH];
	logic [mpt_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [mpt_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [mpt_pkg::QPTR_W:0]     fill_q;

	assign full       = fill_q == (mpt_pkg::QPTR_W + 1)'(mpt_pkg::QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head       = slots_q[rd_ptr_q];

	function automatic logic [mpt_pkg::QPTR_W-1:0] next_ptr(
		input logic [mpt_pkg::QPTR_W-1:0] p);
		return (p == mpt_pkg::QPTR_W'(mpt_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop) fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_cmd;
	end

endmodule

// ===== sv/mpt_back.sv =====
// ----------------------------------------------------------------------------
// mpt_back: table memory and command execution
// clears the table after reset, fills ranges, serves lookups and raw reads
// ----------------------------------------------------------------------------
module mpt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  mpt_pkg::cmd_t       head,
	output logic                pop,
	output logic                clearing,
	mpt_rsp_if.source           rsp
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_RUN,
		S_FILL
	} state_t;

	state_t                          state_q;
	logic [mpt_pkg::IDX_W-1:0]       idx_q;
	logic [mpt_pkg::IDX_W-1:0]       fill_i_q;
	logic [mpt_pkg::CNT_W-1:0]       fill_left_q;
	logic [mpt_pkg::BASE_W-1:0]      fill_base_q;
	logic [mpt_pkg::ALIGN_W-1:0]     fill_align_q;

	logic                            valid_s1;
	mpt_pkg::kind_t                  kind_s1;
	logic [mpt_pkg::STATUS_W-1:0]    status_s1;
	logic [mpt_pkg::PAGE_SHIFT-1:0]  offset_s1;

	logic                            rsp_valid_q;
	logic [mpt_pkg::BASE_W-1:0]      meta_q;
	logic [mpt_pkg::ENTRY_W-1:0]     entry_q;
	logic [mpt_pkg::STATUS_W-1:0]    status_q;

	logic [mpt_pkg::ENTRY_W-1:0]     mem [mpt_pkg::TABLE_ENTRIES];
	logic [mpt_pkg::ENTRY_W-1:0]     rdata_q;

	logic                            out_free;
	logic                            s1_free;
	logic                            s1_adv;
	logic                            mem_we;
	logic                            mem_re;
	logic [mpt_pkg::ENTRY_W-1:0]     mem_wdata;

	logic [mpt_pkg::IDX_W+mpt_pkg::PAGE_SHIFT-1:0] fill_scaled;
	logic [mpt_pkg::BASE_W-1:0]      fill_meta;
	logic [mpt_pkg::ALIGN_BYTE_W-1:0] al_byte;
	logic [mpt_pkg::PAGE_SHIFT-1:0]  lk_scaled;
	logic [mpt_pkg::BASE_W-1:0]      lk_meta;

	assign clearing = state_q == S_CLEAR;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign s1_free  = !valid_s1 || out_free;
	assign s1_adv   = valid_s1 && out_free;
	assign pop      = (state_q == S_RUN) && head_valid && s1_free;
	assign mem_re   = pop && (head.kind == mpt_pkg::KIND_LOOKUP || head.kind == mpt_pkg::KIND_RAW);
	assign mem_we   = (state_q == S_CLEAR) || (state_q == S_FILL);

	// entry for page i of a range
	assign fill_scaled = {fill_i_q, mpt_pkg::PAGE_SHIFT'(0)} >> fill_align_q;
	assign fill_meta   = (fill_base_q == '0) ? '0
		: fill_base_q + mpt_pkg::scale_unit(mpt_pkg::BASE_W'(fill_scaled));
	assign mem_wdata   = (state_q == S_CLEAR) ? '0
		: {fill_meta, mpt_pkg::ALIGN_BYTE_W'(fill_align_q)};

	// lookup address from the registered entry read when the command was popped
	assign al_byte   = rdata_q[mpt_pkg::ALIGN_BYTE_W-1:0];
	assign lk_scaled = (al_byte < mpt_pkg::ALIGN_BYTE_W'(64))
		? offset_s1 >> al_byte[mpt_pkg::ALIGN_W-1:0] : '0;
	assign lk_meta   = rdata_q[mpt_pkg::ENTRY_W-1:mpt_pkg::ALIGN_BYTE_W]
		+ mpt_pkg::scale_unit(mpt_pkg::BASE_W'(lk_scaled));

	assign rsp.valid        = rsp_valid_q;
	assign rsp.meta_address = meta_q;
	assign rsp.entry_word   = entry_q;
	assign rsp.status       = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			idx_q        <= '0;
			fill_i_q     <= '0;
			fill_left_q  <= '0;
			fill_base_q  <= '0;
			fill_align_q <= '0;
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == mpt_pkg::IDX_W'(mpt_pkg::TABLE_ENTRIES - 1)) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (pop && head.kind == mpt_pkg::KIND_FILL) begin
						state_q      <= S_FILL;
						idx_q        <= head.page;
						fill_i_q     <= '0;
						fill_left_q  <= head.count;
						fill_base_q  <= head.base;
						fill_align_q <= head.align;
					end
				end
				S_FILL: begin
					idx_q       <= idx_q + 1'b1;
					fill_i_q    <= fill_i_q + 1'b1;
					fill_left_q <= fill_left_q - 1'b1;
					if (fill_left_q == mpt_pkg::CNT_W'(1)) state_q <= S_RUN;
				end
				default: begin
					state_q <= S_RUN;
				end
			endcase

			if (pop) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;

			if (s1_adv) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1   <= head.kind;
			status_s1 <= head.status;
			offset_s1 <= head.offset;
		end
		if (s1_adv) begin
			status_q <= status_s1;
			case (kind_s1)
				mpt_pkg::KIND_LOOKUP: begin
					meta_q  <= lk_meta;
					entry_q <= rdata_q;
				end
				mpt_pkg::KIND_RAW: begin
					meta_q  <= '0;
					entry_q <= rdata_q;
				end
				default: begin
					meta_q  <= '0;
					entry_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[idx_q] <= mem_wdata;
		if (mem_re) rdata_q <= mem[head.page];
	end

endmodule

// ===== sv/metadata_page_table.sv =====
// ----------------------------------------------------------------------------
// metadata_page_table: per-page table mapping application pages to metadata
// range set, metadata lookup and raw entry read over valid/ready channels
// ----------------------------------------------------------------------------
// a request passes the queue, the read stage and the response register
// throughput: lookups, raw reads and rejected requests one word per cycle,
// while rsp.ready is high; a range set holds the table port page by page
// the table memory port (one write or one read a cycle) sets these rates
// reset: after arst_n the whole table is swept to zero, cmd.ready low
// ----------------------------------------------------------------------------
module metadata_page_table (
	input  logic        clk,
	input  logic        arst_n,
	mpt_cmd_if.sink     cmd,
	mpt_rsp_if.source   rsp
);

	// front to queue
	logic              push;
	mpt_pkg::cmd_t     push_cmd;
	logic              q_full;

	// queue to back
	logic              head_valid;
	mpt_pkg::cmd_t     head;
	logic              pop;

	// back busy with the reset sweep, intake held off
	logic              clearing;

	// intake: range and window checks, no state of its own
	mpt_front u_front (
		.cmd      (cmd),
		.q_full   (q_full),
		.clearing (clearing),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// decouples intake from a range fill
	mpt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// table memory, fill sequencer, read stage and response register
	mpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.rsp        (rsp)
	);

endmodule
